// File: rtl/ftcp_pkg.sv
// shared types, constants and helpers of the framed time command parser
package ftcp_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int FRAME_OVERHEAD  = 5;
    localparam int FIELD_COUNT     = 6;
    localparam int NUM_FIELDS      = 6;

    localparam logic [7:0]  ASCII_ZERO = 8'd48;
    localparam logic [7:0]  ASCII_NINE = 8'd57;
    localparam logic [7:0]  RST_START  = 8'd83;
    localparam logic [7:0]  RST_END    = 8'd69;
    localparam logic [7:0]  RST_TSC    = 8'd49;
    localparam logic [7:0]  RST_SEP    = 8'd45;
    localparam logic [15:0] VALUE_MAX  = 16'hFFFF;
    localparam logic [2:0]  COUNT_MAX  = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_END     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_END   = 2'd1,
        CFG_TSC   = 2'd2,
        CFG_SEP   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_TIME_SET    = 3'd0,
        EV_OTHER_CMD   = 3'd1,
        EV_BAD_MARKERS = 3'd2,
        EV_BAD_COUNT   = 3'd3,
        EV_BAD_LENGTH  = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] time_set_code;
        logic [7:0] field_separator;
    } t_cfg;

    // one finished frame as handed from the parser to the evaluator
    typedef struct packed {
        logic                         bad_len;
        logic                         marks_ok;
        logic [7:0]                   cmd;
        logic [2:0]                   count;
        logic [NUM_FIELDS-1:0][15:0]  fields;
    } t_rec;

    typedef struct packed {
        t_event                       ev;
        logic [7:0]                   cmd;
        logic                         first;
        logic [NUM_FIELDS-1:0][15:0]  fields;
    } t_res;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

endpackage

// File: rtl/framed_time_command_parser_core.sv
// top level of the framed time command parser
//
// Input side is a queue write port: a byte transfers on a clock edge with
// push high and full low. Frames are start byte, command byte, two decimal
// length digits, payload, end byte; payload is split into numeric fields.
// Result side is a queue read port: while empty is low the oldest result is
// on the o_ ports, and it transfers on an edge with pop high.
// One byte per cycle is taken while full is low; the parser does all
// per-byte work combinationally and registers it as the byte is taken.
// A frame's record is queued with its last byte; its result is registered.
// Up to two finished frame records wait between parser and evaluator, plus
// one result in the output register; when pop stays low those fill and
// full rises, after which no byte is taken until results drain.
// Configuration writes land on the edge with i_cfg_we high; the user must
// make them only while the block is idle; the block does not enforce it.
// Reset (synchronous, active low) returns the parser to header phase,
// empties all queues, restores the default markers and forgets the first
// accepted frame.
module framed_time_command_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_command_code,
    output logic        o_first_accepted,
    output logic [15:0] o_year_value,
    output logic [15:0] o_month_value,
    output logic [15:0] o_day_value,
    output logic [15:0] o_hour_value,
    output logic [15:0] o_minute_value,
    output logic [15:0] o_second_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import ftcp_pkg::*;

    t_cfg r_cfg;
    logic w_accept;
    logic w_rec_push;
    t_rec w_rec_in;
    t_rec w_rec_out;
    logic w_q_full;
    logic w_q_empty;
    logic w_rec_take;
    logic w_res_valid;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker    <= RST_START;
            r_cfg.end_marker      <= RST_END;
            r_cfg.time_set_code   <= RST_TSC;
            r_cfg.field_separator <= RST_SEP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START: r_cfg.start_marker    <= i_cfg_data;
                CFG_END:   r_cfg.end_marker      <= i_cfg_data;
                CFG_TSC:   r_cfg.time_set_code   <= i_cfg_data;
                CFG_SEP:   r_cfg.field_separator <= i_cfg_data;
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    assign full     = w_q_full;
    assign w_accept = push && !full;

    ftcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_rx_byte),
        .i_cfg      (r_cfg),
        .o_rec_push (w_rec_push),
        .o_rec      (w_rec_in)
    );

    ftcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_rec_push),
        .i_data  (w_rec_in),
        .i_rd    (w_rec_take),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_rec_out)
    );

    ftcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (!w_q_empty),
        .i_rec           (w_rec_out),
        .i_time_set_code (r_cfg.time_set_code),
        .i_pop           (pop),
        .o_rec_take      (w_rec_take),
        .o_valid         (w_res_valid),
        .o_res           (w_res)
    );

    assign empty            = !w_res_valid;
    assign o_event_res      = w_res.ev;
    assign o_command_code   = w_res.cmd;
    assign o_first_accepted = w_res.first;
    assign o_year_value     = w_res.fields[0];
    assign o_month_value    = w_res.fields[1];
    assign o_day_value      = w_res.fields[2];
    assign o_hour_value     = w_res.fields[3];
    assign o_minute_value   = w_res.fields[4];
    assign o_second_value   = w_res.fields[5];

    // first frame flag only on results that passed the marker check
    a_first_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_first_accepted) |->
        (o_event_res == EV_TIME_SET || o_event_res == EV_OTHER_CMD ||
         o_event_res == EV_BAD_COUNT))
        else $error("first flag on a rejected frame");

    // field values only travel with a time-set result
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_res != EV_TIME_SET) |->
        (o_year_value == 16'd0 && o_month_value == 16'd0 && o_day_value == 16'd0 &&
         o_hour_value == 16'd0 && o_minute_value == 16'd0 && o_second_value == 16'd0))
        else $error("field values on a non time-set result");

    // a waiting result is kept while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_event_res) && $stable(o_command_code)))
        else $error("waiting result changed without a pop");

    // back pressure only once the result register is occupied
    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("record queue full while no result waits");

endmodule

// File: rtl/ftcp_front.sv
// byte parser: frame phase, header decode and on-the-fly field tokenizing
module ftcp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  ftcp_pkg::t_cfg i_cfg,
    output logic          o_rec_push,
    output ftcp_pkg::t_rec o_rec
);
    import ftcp_pkg::*;

    t_phase                      r_phase, n_phase;
    logic [6:0]                  r_idx, n_idx;
    logic [6:0]                  r_len, n_len;
    logic                        r_len_bad, n_len_bad;
    logic [7:0]                  r_start, n_start;
    logic [7:0]                  r_cmd, n_cmd;
    logic [15:0]                 r_val, n_val;
    logic                        r_open, n_open;
    logic                        r_done, n_done;
    logic [2:0]                  r_cnt, n_cnt;
    logic [NUM_FIELDS-1:0][15:0] r_fields, n_fields;

    logic        w_sep;
    logic        w_dig;
    logic [3:0]  w_digit;
    logic [19:0] w_acc;
    logic [6:0]  w_len_sum;
    logic        w_last;
    logic        w_push;

    assign w_sep   = (i_byte == i_cfg.field_separator);
    assign w_dig   = is_digit(i_byte);
    assign w_digit = w_dig ? i_byte[3:0] - ASCII_ZERO[3:0] : 4'd0;
    assign w_len_sum = r_len + {3'b000, w_digit};

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_len    = r_len;
        n_len_bad = r_len_bad;
        n_start  = r_start;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_open   = r_open;
        n_done   = r_done;
        n_cnt    = r_cnt;
        n_fields = r_fields;
        w_push   = 1'b0;
        w_acc    = '0;
        w_last   = 1'b0;
        o_rec          = '0;
        o_rec.cmd      = r_cmd;
        o_rec.count    = r_cnt;
        o_rec.fields   = r_fields;
        o_rec.marks_ok = (r_start == i_cfg.start_marker) && (i_byte == i_cfg.end_marker);

        unique case (r_phase)
            PH_PAYLOAD: begin
                if (!w_sep) begin
                    if (!r_open) begin
                        n_open = 1'b1;
                        n_val  = '0;
                        n_done = 1'b0;
                        if (r_cnt != COUNT_MAX) begin
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                    // value*10 + digit, saturating at 16 bits
                    w_acc = {1'b0, n_val, 3'b000} + {3'b000, n_val, 1'b0}
                          + {16'd0, w_digit};
                    if (!n_done && w_dig) begin
                        n_val = (w_acc[19:16] != 4'd0) ? VALUE_MAX : w_acc[15:0];
                    end else begin
                        n_done = 1'b1;
                    end
                end
                n_idx  = r_idx + 7'd1;
                w_last = (n_idx >= r_len);
                if ((w_sep || w_last) && n_open) begin
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (k < FIELD_COUNT && 3'(k) == n_cnt - 3'd1) begin
                            n_fields[k] = n_val;
                        end
                    end
                    n_open = 1'b0;
                end
                if (w_last) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                w_push  = 1'b1;
                n_phase = PH_HEADER;
                n_idx   = '0;
            end
            default: begin
                n_phase = PH_HEADER;
                unique case (r_idx)
                    7'd0: begin
                        n_start = i_byte;
                        n_idx   = 7'd1;
                    end
                    7'd1: begin
                        n_cmd = i_byte;
                        n_idx = 7'd2;
                    end
                    7'd2: begin
                        n_len_bad = !w_dig;
                        n_len     = 7'({3'b000, w_digit} * 7'd10);
                        n_idx     = 7'd3;
                    end
                    default: begin
                        n_idx = '0;
                        if (r_len_bad || !w_dig) begin
                            n_len         = '0;
                            w_push        = 1'b1;
                            o_rec.bad_len = 1'b1;
                        end else if (({2'b00, w_len_sum} + 9'(FRAME_OVERHEAD))
                                     > 9'(MAX_FRAME_BYTES)) begin
                            n_len = '0;
                        end else begin
                            n_len    = w_len_sum;
                            n_val    = '0;
                            n_open   = 1'b0;
                            n_done   = 1'b0;
                            n_cnt    = '0;
                            n_fields = '0;
                            n_phase  = (w_len_sum == 7'd0) ? PH_END : PH_PAYLOAD;
                        end
                    end
                endcase
            end
        endcase
    end

    assign o_rec_push = i_accept && w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_idx     <= '0;
            r_len     <= '0;
            r_len_bad <= 1'b0;
            r_start   <= '0;
            r_cmd     <= '0;
            r_val     <= '0;
            r_open    <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_fields  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_len_bad <= n_len_bad;
            r_start   <= n_start;
            r_cmd     <= n_cmd;
            r_val     <= n_val;
            r_open    <= n_open;
            r_done    <= n_done;
            r_cnt     <= n_cnt;
            r_fields  <= n_fields;
        end
    end

endmodule

// File: rtl/ftcp_queue.sv
// two-entry frame record queue between parser and evaluator
module ftcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ftcp_pkg::t_rec i_data,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output ftcp_pkg::t_rec o_data
);
    import ftcp_pkg::*;

    t_rec       r_mem [0:1];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// File: rtl/ftcp_back.sv
// evaluator: turns a frame record into a result and holds it for transfer
module ftcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    input  ftcp_pkg::t_rec i_rec,
    input  logic [7:0]     i_time_set_code,
    input  logic           i_pop,
    output logic           o_rec_take,
    output logic           o_valid,
    output ftcp_pkg::t_res o_res
);
    import ftcp_pkg::*;

    logic r_valid;
    logic r_first_done;
    t_res r_res;
    t_res w_res;
    logic w_accepted;

    assign o_rec_take = i_rec_valid && (!r_valid || i_pop);
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_comb begin
        w_res      = '0;
        w_res.cmd  = i_rec.cmd;
        w_accepted = 1'b0;
        if (i_rec.bad_len) begin
            w_res.ev = EV_BAD_LENGTH;
        end else if (!i_rec.marks_ok) begin
            w_res.ev = EV_BAD_MARKERS;
        end else begin
            w_accepted  = 1'b1;
            w_res.first = !r_first_done;
            if (i_rec.cmd != i_time_set_code) begin
                w_res.ev = EV_OTHER_CMD;
            end else if (i_rec.count != 3'(FIELD_COUNT)) begin
                w_res.ev = EV_BAD_COUNT;
            end else begin
                w_res.ev     = EV_TIME_SET;
                w_res.fields = i_rec.fields;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_first_done <= 1'b0;
        end else begin
            if (o_rec_take) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
            if (o_rec_take && w_accepted) begin
                r_first_done <= 1'b1;
            end
        end
    end

endmodule
